// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the scaler RTL.
// Depends on nothing; define NO_ASSERTIONS to compile the checks away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// The property must hold at every clock edge outside reset.
`define ASSERT_HOLDS(label, clk, rstn, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
// The condition must never be seen at a clock edge outside reset.
`define ASSERT_NEVER(label, clk, rstn, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);
`else
`define ASSERT_HOLDS(label, clk, rstn, prop, msg)
`define ASSERT_NEVER(label, clk, rstn, cond, msg)
`endif
`endif

// ===== hw/rtl/bps_pkg.sv =====
// Shared codes and types of the bilinear pyramid scaler.
// Used by the sample store and the top level.
`default_nettype none
package bps_pkg;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 10;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CHANNELS   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BASE_SIZE  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TOP_LEVEL  = 3'd4;

  // Item kinds and result status codes.
  localparam logic FUNC_STORE   = 1'b0;
  localparam logic FUNC_REQUEST = 1'b1;
  localparam logic STATUS_OK    = 1'b0;
  localparam logic STATUS_BAD   = 1'b1;

  typedef struct packed {
    logic       status;
    logic [7:0] sample;
  } result_t;
endpackage
`default_nettype wire

// ===== hw/rtl/bps_fifo.sv =====
// Small register queue with a combinational head.
// Stands alone; uses the shared assertion macros.
`default_nettype none
`include "assert_macros.svh"
module bps_fifo #(
  parameter int unsigned W     = 8,
  parameter int unsigned DEPTH = 32
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         push_i,
  input  wire logic [W-1:0] data_i,
  input  wire logic         pop_i,
  output logic              valid_o,
  output logic [W-1:0]      data_o
);
  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem_q [DEPTH];
  logic [PW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CW-1:0] cnt_q, cnt_d;

  // Pointers wrap at the queue depth.
  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    if (push_i) begin
      wr_d = (32'(wr_q) == DEPTH - 1) ? '0 : wr_q + 1'b1;
    end
    if (pop_i) begin
      rd_d = (32'(rd_q) == DEPTH - 1) ? '0 : rd_q + 1'b1;
    end
    cnt_d = cnt_q + CW'(push_i) - CW'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_q];

  `ASSERT_NEVER(a_no_overflow, clk_i, rst_ni, push_i && !pop_i && 32'(cnt_q) == DEPTH, "queue overflow")
  `ASSERT_NEVER(a_no_underflow, clk_i, rst_ni, pop_i && cnt_q == '0, "queue underflow")
endmodule
`default_nettype wire

// ===== hw/rtl/bps_div.sv =====
// Pipelined restoring divider, two lanes sharing one divisor.
// One quotient bit per stage; stands alone.
`default_nettype none
module bps_div #(
  parameter int unsigned NW = 38,
  parameter int unsigned DW = 11,
  parameter int unsigned QW = 18,
  parameter int unsigned PW = 8
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  input  wire logic [NW-1:0] num_a_i,
  input  wire logic [NW-1:0] num_b_i,
  input  wire logic [DW-1:0] den_i,
  input  wire logic [PW-1:0] pay_i,
  output logic               out_valid_o,
  output logic [QW-1:0]      quo_a_o,
  output logic [QW-1:0]      quo_b_o,
  output logic [PW-1:0]      pay_o
);
  logic          vld_q   [QW+1];
  logic [DW-1:0] rem_a_q [QW+1];
  logic [DW-1:0] rem_b_q [QW+1];
  logic [QW-1:0] quo_a_q [QW+1];
  logic [QW-1:0] quo_b_q [QW+1];
  logic [NW-1:0] num_a_q [QW+1];
  logic [NW-1:0] num_b_q [QW+1];
  logic [DW-1:0] den_q   [QW+1];
  logic [PW-1:0] pay_q   [QW+1];

  // Load stage: the top bits of the dividend are already below the divisor.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else begin
      vld_q[0] <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_a_q[0] <= DW'(num_a_i >> QW);
    rem_b_q[0] <= DW'(num_b_i >> QW);
    quo_a_q[0] <= '0;
    quo_b_q[0] <= '0;
    num_a_q[0] <= num_a_i;
    num_b_q[0] <= num_b_i;
    den_q[0]   <= den_i;
    pay_q[0]   <= pay_i;
  end

  // Each stage brings down one dividend bit and decides one quotient bit.
  for (genvar k = 1; k <= QW; k++) begin : g_stage
    logic [DW:0] ta, tb;
    logic        ge_a, ge_b;

    assign ta   = {rem_a_q[k-1], num_a_q[k-1][QW-k]};
    assign tb   = {rem_b_q[k-1], num_b_q[k-1][QW-k]};
    assign ge_a = (ta >= {1'b0, den_q[k-1]});
    assign ge_b = (tb >= {1'b0, den_q[k-1]});

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else begin
        vld_q[k] <= vld_q[k-1];
      end
    end

    always_ff @(posedge clk_i) begin
      rem_a_q[k] <= ge_a ? DW'(ta - {1'b0, den_q[k-1]}) : DW'(ta);
      rem_b_q[k] <= ge_b ? DW'(tb - {1'b0, den_q[k-1]}) : DW'(tb);
      quo_a_q[k] <= {quo_a_q[k-1][QW-2:0], ge_a};
      quo_b_q[k] <= {quo_b_q[k-1][QW-2:0], ge_b};
      num_a_q[k] <= num_a_q[k-1];
      num_b_q[k] <= num_b_q[k-1];
      den_q[k]   <= den_q[k-1];
      pay_q[k]   <= pay_q[k-1];
    end
  end

  assign out_valid_o = vld_q[QW];
  assign quo_a_o     = quo_a_q[QW];
  assign quo_b_o     = quo_b_q[QW];
  assign pay_o       = pay_q[QW];
endmodule
`default_nettype wire

// ===== hw/rtl/bps_store.sv =====
// Source sample memory, read sequencer and bilinear blend pipeline.
// Depends on bps_pkg and the shared assertion macros.
`default_nettype none
`include "assert_macros.svh"
module bps_store
  import bps_pkg::*;
#(
  parameter int unsigned AW        = 9,
  parameter int unsigned CW        = 2,
  parameter int unsigned FRAC_BITS = 8
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 ent_valid_i,
  output logic                      ent_pop_o,
  input  wire logic                 ent_func_i,
  input  wire logic                 ent_bad_i,
  input  wire logic [CW-1:0]        ent_ch_i,
  input  wire logic [7:0]           ent_smp_i,
  input  wire logic [AW-1:0]        ent_x0_i,
  input  wire logic [AW-1:0]        ent_x1_i,
  input  wire logic [AW-1:0]        ent_y0_i,
  input  wire logic [AW-1:0]        ent_y1_i,
  input  wire logic [FRAC_BITS-1:0] ent_wx_i,
  input  wire logic [FRAC_BITS-1:0] ent_wy_i,
  output logic                      stored_o,
  output logic                      res_valid_o,
  output result_t                   res_o
);
  localparam int unsigned MAW = 2 * AW + CW;
  localparam int unsigned VW  = 8 + FRAC_BITS;
  localparam int unsigned WW  = 8 + 2 * FRAC_BITS;
  localparam logic [FRAC_BITS:0] ONE  = (FRAC_BITS + 1)'(1) << FRAC_BITS;
  localparam logic [WW:0]        HALF = (WW + 1)'(1) << (2 * FRAC_BITS - 1);
  // Read phases: one neighbour per cycle.
  localparam logic [1:0] PH_P00 = 2'd0;
  localparam logic [1:0] PH_P01 = 2'd1;
  localparam logic [1:0] PH_P10 = 2'd2;
  localparam logic [1:0] PH_P11 = 2'd3;

  logic [7:0]     mem_q [2**MAW];
  logic [7:0]     rdata_q;
  logic [1:0]     phase_q, phase_d;
  logic           is_read, is_bad_req, we;
  logic [MAW-1:0] waddr, raddr;
  logic [AW-1:0]  rx, ry;

  // Entry decode: a store or a rejected request is popped when seen, a good request after its fourth read.
  assign is_read    = ent_valid_i && ent_func_i == FUNC_REQUEST && !ent_bad_i;
  assign is_bad_req = ent_valid_i && ent_func_i == FUNC_REQUEST && ent_bad_i;
  assign we         = ent_valid_i && ent_func_i == FUNC_STORE;
  assign ent_pop_o  = ent_valid_i && (!is_read || phase_q == PH_P11);
  assign stored_o   = we;
  assign phase_d    = is_read ? phase_q + 2'd1 : PH_P00;

  assign rx    = phase_q[0] ? ent_x1_i : ent_x0_i;
  assign ry    = phase_q[1] ? ent_y1_i : ent_y0_i;
  assign waddr = {ent_y0_i, ent_x0_i, ent_ch_i};
  assign raddr = {ry, rx, ent_ch_i};

  // Items leave the queue in order and use the port one at a time, so a read
  // never meets a write to the same cycle and needs no forwarding.
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= ent_smp_i;
    end
    if (is_read) begin
      rdata_q <= mem_q[raddr];
    end
  end

  // Tag travelling beside the read data.
  logic                 tag_vld_q, tag_last_q, tag_bad_q;
  logic [1:0]           tag_ph_q;
  logic [FRAC_BITS-1:0] tag_wx_q, tag_wy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_P00;
      tag_vld_q <= 1'b0;
    end else begin
      phase_q   <= phase_d;
      tag_vld_q <= is_read || is_bad_req;
    end
  end

  always_ff @(posedge clk_i) begin
    tag_last_q <= is_bad_req || phase_q == PH_P11;
    tag_bad_q  <= ent_bad_i;
    tag_ph_q   <= phase_q;
    tag_wx_q   <= ent_wx_i;
    tag_wy_q   <= ent_wy_i;
  end

  // Hold the first three neighbours; the fourth is used straight from the port.
  logic [7:0] p00_q, p01_q, p10_q;

  always_ff @(posedge clk_i) begin
    if (tag_vld_q && !tag_bad_q) begin
      unique case (tag_ph_q)
        PH_P00: p00_q <= rdata_q;
        PH_P01: p01_q <= rdata_q;
        PH_P10: p10_q <= rdata_q;
        PH_P11: ;
        default: ;
      endcase
    end
  end

  // Horizontal blend of both rows.
  logic [FRAC_BITS:0]   iwx, iwy;
  logic                 s1_vld_q, s1_bad_q;
  logic [VW-1:0]        s1_v0_q, s1_v1_q;
  logic [FRAC_BITS-1:0] s1_wy_q;

  assign iwx = ONE - {1'b0, tag_wx_q};

  always_ff @(posedge clk_i) begin
    s1_bad_q <= tag_bad_q;
    s1_wy_q  <= tag_wy_q;
    s1_v0_q  <= VW'(p00_q) * VW'(iwx) + VW'(p01_q) * VW'(tag_wx_q);
    s1_v1_q  <= VW'(p10_q) * VW'(iwx) + VW'(rdata_q) * VW'(tag_wx_q);
  end

  // Vertical blend.
  logic          s2_vld_q, s2_bad_q;
  logic [WW-1:0] s2_v_q;

  assign iwy = ONE - {1'b0, s1_wy_q};

  always_ff @(posedge clk_i) begin
    s2_bad_q <= s1_bad_q;
    s2_v_q   <= WW'(s1_v0_q) * WW'(iwy) + WW'(s1_v1_q) * WW'(s1_wy_q);
  end

  // Round half up, drop the weight bits and saturate.
  logic [WW:0] rnd;
  logic [8:0]  rsh;
  result_t     res_d, res_q;
  logic        res_vld_q;

  assign rnd = (WW + 1)'(s2_v_q) + HALF;
  assign rsh = rnd[WW:2*FRAC_BITS];

  always_comb begin
    if (s2_bad_q) begin
      res_d.status = STATUS_BAD;
      res_d.sample = 8'd0;
    end else begin
      res_d.status = STATUS_OK;
      res_d.sample = rsh[8] ? 8'hFF : rsh[7:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      s2_vld_q  <= 1'b0;
      res_vld_q <= 1'b0;
    end else begin
      s1_vld_q  <= tag_vld_q && tag_last_q;
      s2_vld_q  <= s1_vld_q;
      res_vld_q <= s2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign res_valid_o = res_vld_q;
  assign res_o       = res_q;

  `ASSERT_HOLDS(a_phase_owner, clk_i, rst_ni, phase_q != PH_P00 |-> ent_valid_i && ent_func_i == FUNC_REQUEST, "read phase without a request at the head")
  `ASSERT_HOLDS(a_bad_is_zero, clk_i, rst_ni, res_vld_q && res_q.status == STATUS_BAD |-> res_q.sample == 8'd0, "rejected request with a sample")
endmodule
`default_nettype wire

// ===== hw/rtl/bilinear_pyramid_image_scaler.sv =====
// Bilinear pyramid image scaler, top level. A store transfer is one write; a
// request makes four neighbour reads, one at a time on the single memory port.
// Request latency is set by the one-bit-per-stage position divider, the four
// reads and three blend stages. Reset clears control state only; the sample
// memory holds nothing defined until written, and needs no clearing pass. Up
// to 32 items are in flight at once.
`default_nettype none
`include "assert_macros.svh"
module bilinear_pyramid_image_scaler
  import bps_pkg::*;
#(
  parameter int unsigned MAX_DIM      = 512,
  parameter int unsigned MAX_CHANNELS = 4,
  parameter int unsigned FRAC_BITS    = 8
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  // tdata: pixel_x[8:0], pixel_y[17:9], chan_index[19:18], sample_in[27:20], level[31:28]
  input  wire logic [31:0]           s_axis_tdata,
  // tuser: func
  input  wire logic                  s_axis_tuser,
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  // tdata: sample_out[7:0]
  output logic [7:0]                 m_axis_tdata,
  // tuser: status
  output logic                       m_axis_tuser
);
  localparam int unsigned AW     = $clog2(MAX_DIM);
  localparam int unsigned DIMW   = AW + 1;
  localparam int unsigned CW     = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int unsigned CCW    = $clog2(MAX_CHANNELS + 1);
  localparam int unsigned DW     = AW + 2;
  localparam int unsigned NW     = 2 * AW + 2 + FRAC_BITS;
  localparam int unsigned QW     = AW + 1 + FRAC_BITS;
  localparam int unsigned QDEPTH = 32;
  localparam int unsigned CNTW   = $clog2(QDEPTH + 1);
  localparam int unsigned PAYW   = 2 + CW + 8 + 2 * AW;

  typedef struct packed {
    logic                 func;
    logic                 bad;
    logic [CW-1:0]        ch;
    logic [7:0]           smp;
    logic [AW-1:0]        x;
    logic [AW-1:0]        y;
  } pay_t;

  typedef struct packed {
    logic                 func;
    logic                 bad;
    logic [CW-1:0]        ch;
    logic [7:0]           smp;
    logic [AW-1:0]        x0;
    logic [AW-1:0]        x1;
    logic [AW-1:0]        y0;
    logic [AW-1:0]        y1;
    logic [FRAC_BITS-1:0] wx;
    logic [FRAC_BITS-1:0] wy;
  } entry_t;

  function automatic logic [DIMW-1:0] sat_dim(input logic [CFG_DATA_W-1:0] v);
    logic [DIMW-1:0] r;
    if (v == '0) begin
      r = DIMW'(1);
    end else if (32'(v) > MAX_DIM) begin
      r = DIMW'(MAX_DIM);
    end else begin
      r = DIMW'(v);
    end
    return r;
  endfunction

  function automatic logic [CCW-1:0] sat_chan(input logic [2:0] v);
    logic [CCW-1:0] r;
    if (v == 3'd0) begin
      r = CCW'(1);
    end else if (32'(v) > MAX_CHANNELS) begin
      r = CCW'(MAX_CHANNELS);
    end else begin
      r = CCW'(v);
    end
    return r;
  endfunction

  // Neighbour indices of one axis from the quotient; lower one is the
  // integer part less one, both clamped to the source.
  function automatic logic [2*AW-1:0] axis_idx(input logic [QW-1:0] q,
                                               input logic [DIMW-1:0] s);
    logic [AW:0] hi, lo, lim;
    hi  = q[QW-1:FRAC_BITS];
    lo  = (hi == '0) ? '0 : hi - 1'b1;
    lim = s - 1'b1;
    if (hi > lim) begin
      hi = lim;
    end
    if (lo > lim) begin
      lo = lim;
    end
    return {lo[AW-1:0], hi[AW-1:0]};
  endfunction

  // Configuration registers; sizes and channel count are saturated on write.
  logic [DIMW-1:0] src_w_q, src_h_q, base_q;
  logic [CCW-1:0]  chan_q;
  logic [3:0]      top_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_w_q <= sat_dim(CFG_DATA_W'(512));
      src_h_q <= sat_dim(CFG_DATA_W'(512));
      chan_q  <= CCW'(1);
      base_q  <= sat_dim(CFG_DATA_W'(256));
      top_q   <= 4'd0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_SRC_WIDTH:  src_w_q <= sat_dim(cfg_data_i);
        REG_SRC_HEIGHT: src_h_q <= sat_dim(cfg_data_i);
        REG_CHANNELS:   chan_q  <= sat_chan(cfg_data_i[2:0]);
        REG_BASE_SIZE:  base_q  <= sat_dim(cfg_data_i);
        REG_TOP_LEVEL:  top_q   <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  // Input decode and range checks.
  logic [8:0]      in_x, in_y;
  logic [1:0]      in_ch;
  logic [7:0]      in_smp;
  logic [3:0]      in_lvl;
  logic [DIMW-1:0] shifted, side;
  logic            accept, store_ok, req_bad, enter;

  assign in_x    = s_axis_tdata[8:0];
  assign in_y    = s_axis_tdata[17:9];
  assign in_ch   = s_axis_tdata[19:18];
  assign in_smp  = s_axis_tdata[27:20];
  assign in_lvl  = s_axis_tdata[31:28];
  assign shifted = base_q >> in_lvl;
  assign side    = (shifted == '0) ? base_q : shifted;
  assign accept  = s_axis_tvalid && s_axis_tready;

  assign store_ok = 32'(in_x) < 32'(src_w_q) && 32'(in_y) < 32'(src_h_q)
                    && 32'(in_ch) < 32'(chan_q);
  assign req_bad  = in_lvl > top_q || 32'(in_x) >= 32'(side) || 32'(in_y) >= 32'(side)
                    || 32'(in_ch) >= 32'(chan_q);
  // Stores outside the source are dropped here and never enter the pipe.
  assign enter    = accept && (s_axis_tuser == FUNC_REQUEST || store_ok);

  // Input register.
  logic            a_vld_q;
  pay_t            a_pay_q;
  logic [DIMW-1:0] a_side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
    end else begin
      a_vld_q <= enter;
    end
  end

  always_ff @(posedge clk_i) begin
    a_pay_q.func <= s_axis_tuser;
    a_pay_q.bad  <= req_bad;
    a_pay_q.ch   <= CW'(in_ch);
    a_pay_q.smp  <= in_smp;
    a_pay_q.x    <= AW'(in_x);
    a_pay_q.y    <= AW'(in_y);
    a_side_q     <= side;
  end

  // Scaled position numerators: ((2o+1)*s + n) << FRAC_BITS over 2n.
  logic [2*AW+1:0] prod_x, prod_y, sum_x, sum_y;
  logic [NW-1:0]   num_x, num_y;
  logic [DW-1:0]   den;

  assign prod_x = (2*AW+2)'({a_pay_q.x, 1'b1}) * (2*AW+2)'(src_w_q);
  assign prod_y = (2*AW+2)'({a_pay_q.y, 1'b1}) * (2*AW+2)'(src_h_q);
  assign sum_x  = prod_x + (2*AW+2)'(a_side_q);
  assign sum_y  = prod_y + (2*AW+2)'(a_side_q);
  assign num_x  = {sum_x, {FRAC_BITS{1'b0}}};
  assign num_y  = {sum_y, {FRAC_BITS{1'b0}}};
  assign den    = {a_side_q, 1'b0};

  logic          d_vld;
  logic [QW-1:0] d_qx, d_qy;
  logic [PAYW-1:0] d_pay_raw;
  pay_t          d_pay;

  bps_div #(
    .NW (NW),
    .DW (DW),
    .QW (QW),
    .PW (PAYW)
  ) u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (a_vld_q),
    .num_a_i     (num_x),
    .num_b_i     (num_y),
    .den_i       (den),
    .pay_i       (a_pay_q),
    .out_valid_o (d_vld),
    .quo_a_o     (d_qx),
    .quo_b_o     (d_qy),
    .pay_o       (d_pay_raw)
  );

  assign d_pay = pay_t'(d_pay_raw);

  // Neighbour indices and weights; stores carry their own coordinates.
  logic [2*AW-1:0] ix, iy;
  entry_t          q_in, q_out;
  logic            q_vld, q_pop;

  assign ix = axis_idx(d_qx, src_w_q);
  assign iy = axis_idx(d_qy, src_h_q);

  always_comb begin
    q_in.func = d_pay.func;
    q_in.bad  = d_pay.bad;
    q_in.ch   = d_pay.ch;
    q_in.smp  = d_pay.smp;
    q_in.x0   = (d_pay.func == FUNC_STORE) ? d_pay.x : ix[2*AW-1:AW];
    q_in.y0   = (d_pay.func == FUNC_STORE) ? d_pay.y : iy[2*AW-1:AW];
    q_in.x1   = ix[AW-1:0];
    q_in.y1   = iy[AW-1:0];
    q_in.wx   = d_qx[FRAC_BITS-1:0];
    q_in.wy   = d_qy[FRAC_BITS-1:0];
  end

  bps_fifo #(
    .W     ($bits(entry_t)),
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (d_vld),
    .data_i  (q_in),
    .pop_i   (q_pop),
    .valid_o (q_vld),
    .data_o  (q_out)
  );

  logic    stored, res_vld;
  result_t res;

  bps_store #(
    .AW        (AW),
    .CW        (CW),
    .FRAC_BITS (FRAC_BITS)
  ) u_store (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ent_valid_i (q_vld),
    .ent_pop_o   (q_pop),
    .ent_func_i  (q_out.func),
    .ent_bad_i   (q_out.bad),
    .ent_ch_i    (q_out.ch),
    .ent_smp_i   (q_out.smp),
    .ent_x0_i    (q_out.x0),
    .ent_x1_i    (q_out.x1),
    .ent_y0_i    (q_out.y0),
    .ent_y1_i    (q_out.y1),
    .ent_wx_i    (q_out.wx),
    .ent_wy_i    (q_out.wy),
    .stored_o    (stored),
    .res_valid_o (res_vld),
    .res_o       (res)
  );

  // Output queue parts the result stream from the sink.
  result_t o_data;
  logic    out_pop;

  assign out_pop = m_axis_tvalid && m_axis_tready;

  bps_fifo #(
    .W     ($bits(result_t)),
    .DEPTH (QDEPTH)
  ) u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_vld),
    .data_i  (res),
    .pop_i   (out_pop),
    .valid_o (m_axis_tvalid),
    .data_o  (o_data)
  );

  assign m_axis_tdata = o_data.sample;
  assign m_axis_tuser = o_data.status;

  // Items in flight; bounded by the queue depth so neither queue can overflow.
  logic [CNTW-1:0] cnt_q, cnt_d;

  assign cnt_d = cnt_q + CNTW'(enter) - CNTW'(stored) - CNTW'(out_pop);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  assign s_axis_tready = 32'(cnt_q) < QDEPTH;

  `ASSERT_HOLDS(a_cnt_bound, clk_i, rst_ni, 32'(cnt_q) <= QDEPTH, "in-flight count beyond queue depth")
  `ASSERT_HOLDS(a_res_counted, clk_i, rst_ni, res_vld |-> cnt_q != '0, "result with no item in flight")
endmodule
`default_nettype wire

// ===== bench/tb.sv =====
// Self-checking bench for the bilinear pyramid image scaler.
// Needs bps_pkg and the scaler RTL; it predicts every output sample and compares.
`default_nettype none
module tb
  import bps_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DIM      = 512;
  localparam int unsigned CHANS    = 4;
  localparam int unsigned FRAC     = 8;
  localparam int unsigned DRAIN    = 60;
  localparam longint      MAX_CYC  = 3000000;

  typedef struct packed {
    logic       func;
    logic [3:0] level;
    logic [7:0] sample_in;
    logic [1:0] chan;
    logic [8:0] py;
    logic [8:0] px;
  } pixel_item_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic s_axis_tuser = 1'b0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;
  logic m_axis_tuser;

  bilinear_pyramid_image_scaler uut (.*);

  // Clock: 10 ns period.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Predictor state: own copy of the store and the registers.
  logic [7:0] pix_mem [int unsigned];
  int unsigned cur_w, cur_h, cur_ch, cur_base, cur_top;
  pixel_item_t pending_items[$];
  result_t     expected_samples[$];
  int unsigned fails = 0;
  int unsigned send_idle = 6, recv_idle = 83;
  longint      cycles = 0;
  // Set at each rising edge that completed an input transfer.
  bit          in_fire = 1'b0;
  // Map for pixels written with the current geometry; nothing fills or reads it.
  bit          filled [int unsigned];

  function automatic int unsigned mem_addr(int unsigned x, y, c);
    return (y * DIM + x) * CHANS + c;
  endfunction

  function automatic int unsigned sat(int unsigned v, lo, hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic void apply_reg(int unsigned idx, int unsigned val);
    case (idx)
      REG_SRC_WIDTH:  cur_w    = sat(val & 10'h3ff, 1, DIM);
      REG_SRC_HEIGHT: cur_h    = sat(val & 10'h3ff, 1, DIM);
      REG_CHANNELS:   cur_ch   = sat(val & 3'h7, 1, CHANS);
      REG_BASE_SIZE:  cur_base = sat(val & 10'h3ff, 1, DIM);
      REG_TOP_LEVEL:  cur_top  = val & 4'hf;
      default: ;
    endcase
  endfunction

  // Neighbour indices and quantised weight along one axis.
  function automatic void axis_neighbours(int unsigned o, n, s,
                                          output int unsigned i0, i1, w);
    longint num, den, lo, rem, hi;
    num = longint'(2 * o + 1) * s - n;
    den = 2 * n;
    if (num < 0) begin
      lo = -1;
      rem = num + den;
    end else begin
      lo = num / den;
      rem = num % den;
    end
    w = 32'((rem << FRAC) / den);
    hi = lo + 1;
    if (lo < 0) lo = 0;
    if (lo >= s) lo = s - 1;
    if (hi >= s) hi = s - 1;
    i0 = 32'(lo);
    i1 = 32'(hi);
  endfunction

  function automatic longint read_pix(int unsigned a);
    return pix_mem.exists(a) ? pix_mem[a] : 0;
  endfunction

  // Updates the store or works out one resampled sample.
  function automatic void predict_pixel(pixel_item_t it);
    int unsigned side, x0, x1, y0, y1, wx, wy;
    longint s, v0, v1, v, r;
    result_t res;
    if (it.func == FUNC_STORE) begin
      if (it.px < cur_w && it.py < cur_h && it.chan < cur_ch)
        pix_mem[mem_addr(it.px, it.py, it.chan)] = it.sample_in;
      return;
    end
    side = cur_base >> it.level;
    if (side == 0) side = cur_base;
    if (it.level > cur_top || it.px >= side || it.py >= side || it.chan >= cur_ch) begin
      res.status = STATUS_BAD;
      res.sample = '0;
    end else begin
      axis_neighbours(it.py, side, cur_h, y0, y1, wy);
      axis_neighbours(it.px, side, cur_w, x0, x1, wx);
      s = 1 << FRAC;
      v0 = read_pix(mem_addr(x0, y0, it.chan)) * (s - wx)
         + read_pix(mem_addr(x1, y0, it.chan)) * wx;
      v1 = read_pix(mem_addr(x0, y1, it.chan)) * (s - wx)
         + read_pix(mem_addr(x1, y1, it.chan)) * wx;
      v = v0 * (s - wy) + v1 * wy;
      r = (v + ((s * s) >> 1)) >> (2 * FRAC);
      if (r > 255) r = 255;
      res.status = STATUS_OK;
      res.sample = r[7:0];
    end
    expected_samples.push_back(res);
  endfunction

  // Driver: one item per transfer, idling at random; a waiting item is held.
  always @(negedge clk_i) begin
    pixel_item_t it;
    if (rst_ni) begin
      if (!s_axis_tvalid || in_fire) begin
        if (pending_items.size() > 0 && $urandom_range(99) >= send_idle) begin
          it = pending_items[0];
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {it.level, it.sample_in, it.chan, it.py, it.px};
          s_axis_tuser  <= it.func;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
      m_axis_tready <= $urandom_range(99) >= recv_idle;
    end
  end

  // Accepted transfers: predict on input, compare on output.
  always @(posedge clk_i) begin
    pixel_item_t it;
    result_t want;
    cycles <= cycles + 1;
    in_fire = rst_ni && s_axis_tvalid && s_axis_tready;
    if (in_fire) begin
      it = pending_items.pop_front();
      predict_pixel(it);
    end
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_samples.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual sample %0d status %0d",
                 $realtime, m_axis_tdata, m_axis_tuser);
        fails++;
      end else begin
        want = expected_samples.pop_front();
        if (want.sample !== m_axis_tdata || want.status !== m_axis_tuser) begin
          $display("%0t: mismatch, expected sample %0d status %0d, actual sample %0d status %0d",
                   $realtime, want.sample, want.status, m_axis_tdata, m_axis_tuser);
          fails++;
        end
      end
    end
    if (cycles > MAX_CYC) begin
      $display("simulation failed");
      $finish;
    end
  end

  function automatic pixel_item_t make_item(bit f, int unsigned x, y, c, smp, lvl);
    pixel_item_t it;
    it.func = f;
    it.px = 9'(x);
    it.py = 9'(y);
    it.chan = 2'(c);
    it.sample_in = 8'(smp);
    it.level = 4'(lvl);
    return it;
  endfunction

  // Waits until the block has drained all outstanding work.
  task automatic wait_idle();
    while (pending_items.size() > 0 || s_axis_tvalid || expected_samples.size() > 0)
      @(posedge clk_i);
    repeat (DRAIN) @(posedge clk_i);
  endtask

  task automatic write_reg(int unsigned idx, int unsigned val);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_IDX_W'(idx);
    cfg_data_i <= CFG_DATA_W'(val);
    apply_reg(idx, val);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Sets geometry, then loads every sample of the source image.
  task automatic load_image(int unsigned w, h, c, base, top);
    write_reg(REG_SRC_WIDTH, w);
    write_reg(REG_SRC_HEIGHT, h);
    write_reg(REG_CHANNELS, c);
    write_reg(REG_BASE_SIZE, base);
    write_reg(REG_TOP_LEVEL, top);
    for (int unsigned y = 0; y < cur_h; y++)
      for (int unsigned x = 0; x < cur_w; x++)
        for (int unsigned k = 0; k < cur_ch; k++)
          pending_items.push_back(make_item(FUNC_STORE, x, y, k, $urandom_range(255), 0));
  endtask

  // Random requests, mostly inside the level, plus stray requests and in-range stores.
  task automatic random_requests(int unsigned n);
    int unsigned lvl, side;
    for (int unsigned i = 0; i < n; i++) begin
      lvl = $urandom_range(cur_top + 1);
      side = cur_base >> lvl;
      if (side == 0) side = cur_base;
      case ($urandom_range(9))
        0: pending_items.push_back(make_item(FUNC_REQUEST, $urandom_range(511),
             $urandom_range(511), $urandom_range(3), $urandom, $urandom_range(15)));
        1: pending_items.push_back(make_item(FUNC_STORE, $urandom_range(cur_w - 1),
             $urandom_range(cur_h - 1), $urandom_range(cur_ch - 1), $urandom, $urandom));
        default: pending_items.push_back(make_item(FUNC_REQUEST,
             $urandom_range(side - 1), $urandom_range(side - 1),
             $urandom_range(cur_ch - 1), $urandom, lvl));
      endcase
    end
  endtask

  initial begin
    cur_w = 512; cur_h = 512; cur_ch = 1; cur_base = 256; cur_top = 0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: tiny image, corners, bad level, bad channel, ignored stores.
    load_image(2, 2, 2, 4, 2);
    pending_items.push_back(make_item(FUNC_STORE, 511, 511, 3, 8'hff, 4'hf));
    pending_items.push_back(make_item(FUNC_REQUEST, 0, 0, 0, 0, 0));
    pending_items.push_back(make_item(FUNC_REQUEST, 3, 3, 1, 0, 0));
    pending_items.push_back(make_item(FUNC_REQUEST, 1, 0, 0, 0, 1));
    pending_items.push_back(make_item(FUNC_REQUEST, 0, 0, 0, 0, 2));
    pending_items.push_back(make_item(FUNC_REQUEST, 0, 0, 0, 0, 3));
    pending_items.push_back(make_item(FUNC_REQUEST, 4, 0, 0, 0, 0));
    pending_items.push_back(make_item(FUNC_REQUEST, 0, 0, 2, 0, 0));
    pending_items.push_back(make_item(FUNC_REQUEST, 511, 511, 3, 8'hff, 4'hf));
    wait_idle();

    // Out-of-range writes saturate; image of one pixel, upscale hard.
    load_image(0, 0, 0, 1023, 9);
    pending_items.push_back(make_item(FUNC_REQUEST, 511, 511, 0, 0, 0));
    pending_items.push_back(make_item(FUNC_REQUEST, 0, 0, 0, 0, 9));
    random_requests(40);
    wait_idle();

    // Wide image, downscaled across and upscaled down, first idling pattern.
    load_image(40, 3, 3, 7, 3);
    random_requests(170);
    wait_idle();

    send_idle = 83; recv_idle = 6;
    load_image(5, 17, 4, 33, 6);
    random_requests(170);
    wait_idle();

    send_idle = 0; recv_idle = 0;
    load_image(9, 9, 1, 512, 9);
    random_requests(170);
    wait_idle();

    if (fails == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
`default_nettype wire

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/bps_pkg.sv
hw/rtl/bps_fifo.sv
hw/rtl/bps_div.sv
hw/rtl/bps_store.sv
hw/rtl/bilinear_pyramid_image_scaler.sv
bench/tb.sv
